/* rtl/core/bow_pkg.sv */
// Shared types and constants for the bone octahedron wireframe block.
// Used by bow_front, bow_engine, bow_emit and bone_octahedron_wireframe_top.
// No dependencies.
package bow_pkg;

    // Coordinate fraction bits and the fixed-point scale of unit vectors.
    localparam int FRAC_BITS   = 16;
    localparam int UNIT_BITS   = 30;
    localparam int CRD_W       = 32;
    localparam int SCALE_W     = 16;
    localparam int NUM_SEG     = 12;

    // Shortest bone that still gets drawn: round(0.0001 * 2^FRAC_BITS).
    localparam longint MIN_LEN_RAW = ((64'(1) << FRAC_BITS) + 5000) / 10000;
    // 0.9 in Q2.30, the limit on |dir.z| above which X is the reference axis.
    localparam longint UPSWITCH_Q30 = 966367642;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3277;

    // Step counts of the serial multiplier, divider and square root units.
    localparam logic [5:0] MUL_STEPS  = 6'd34;
    localparam logic [5:0] DIV_STEPS  = 6'd31;
    localparam logic [5:0] SQRT_STEPS = 6'd33;

    typedef logic [2:0][CRD_W-1:0] t_vec3;

    // One bone as it was pushed.
    typedef struct packed {
        t_vec3            p_start;
        t_vec3            p_end;
        logic [CRD_W-1:0] color;
    } t_bone;

    // A finished bone: end points, colour and the four ring vertices.
    typedef struct packed {
        t_vec3            p_start;
        t_vec3            p_end;
        logic [CRD_W-1:0] color;
        logic [3:0][2:0][CRD_W-1:0] vert;
    } t_ring;

    // One line segment on the result side.
    typedef struct packed {
        t_vec3            pa;
        t_vec3            pb;
        logic [CRD_W-1:0] color;
        logic             last;
    } t_seg;

    // Handshake between two internal stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    // Sequencer steps of the arithmetic engine.
    typedef enum logic [3:0] {
        E_IDLE,
        E_SQ,
        E_LEN,
        E_UDIV,
        E_REF,
        E_RSQ,
        E_RSQRT,
        E_RDIV,
        E_CROSS,
        E_USQ,
        E_USQRT,
        E_PDIV,
        E_RAD,
        E_OFF,
        E_VERT,
        E_DONE
    } t_eng_state;

endpackage

/* rtl/core/bow_front.sv */
// Input side of the bone octahedron block: a two-entry queue of bones.
// Depends on bow_pkg for the bone type.
module bow_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bow_pkg::t_bone i_bone,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_take,
    output bow_pkg::t_bone o_bone
);

    bow_pkg::t_bone r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp, n_rp;
    logic [1:0]     n_cnt;
    logic           wr_en, rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_bone  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wp  = wr_en ? !r_wp : r_wp;
        n_rp  = rd_en ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage for the queued bones.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_bone;
        end
    end

endmodule

/* rtl/core/bow_engine.sv */
// Arithmetic back end: length, unit vectors, ring axes and ring vertices of one bone,
// computed with one serial multiplier, one restoring divider and one square root unit.
// Depends on bow_pkg.
module bow_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bow_pkg::SCALE_W-1:0]    i_scale,
    input  bow_pkg::t_hs                   i_in_hs,
    output logic                           o_take,
    input  bow_pkg::t_bone                 i_bone,
    output logic                           o_valid,
    input  logic                           i_ready,
    output bow_pkg::t_ring                 o_ring
);

    bow_pkg::t_eng_state r_state, n_state;
    logic       r_go, n_go;
    logic [2:0] r_k, n_k;
    logic [5:0] r_cnt, n_cnt;

    bow_pkg::t_bone r_bone, n_bone;
    logic signed [32:0] r_d [3];
    logic signed [32:0] n_d [3];
    logic [65:0] r_acc, n_acc;
    logic [32:0] r_len, n_len;
    logic [32:0] r_nrm, n_nrm;
    logic [32:0] r_rad, n_rad;
    logic signed [31:0] r_u [3];
    logic signed [31:0] n_u [3];
    logic signed [31:0] r_r [3];
    logic signed [31:0] n_r [3];
    logic signed [31:0] r_up [3];
    logic signed [31:0] n_up [3];
    logic signed [65:0] r_cx, n_cx;
    logic signed [34:0] r_ro [3];
    logic signed [34:0] n_ro [3];
    logic signed [34:0] r_uo [3];
    logic signed [34:0] n_uo [3];
    bow_pkg::t_ring r_ring, n_ring;

    // Serial unit registers.
    logic [33:0] r_ma, n_ma;
    logic [67:0] r_mp, n_mp;
    logic        r_msg, n_msg;
    logic [32:0] r_dd, n_dd;
    logic [33:0] r_rm, n_rm;
    logic [30:0] r_q, n_q;
    logic        r_dsg, n_dsg;
    logic [65:0] r_sx, n_sx;
    logic [35:0] r_sr, n_sr;
    logic [32:0] r_sq, n_sq;

    logic fin;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // One shift-add step of the multiplier.
    logic [34:0]        mul_t;
    logic [67:0]        mul_nx;
    logic signed [65:0] mul_sp;
    assign mul_t  = {1'b0, r_mp[67:34]} + (r_mp[0] ? {1'b0, r_ma} : 35'd0);
    assign mul_nx = {mul_t, r_mp[33:1]};
    assign mul_sp = r_msg ? -$signed({2'b00, mul_nx[63:0]}) : $signed({2'b00, mul_nx[63:0]});

    // One step of the restoring divider.
    logic        div_ge;
    logic [33:0] div_df;
    logic [30:0] div_q;
    logic [33:0] div_rm;
    logic signed [31:0] div_res;
    assign div_ge  = (r_rm >= {1'b0, r_dd});
    assign div_df  = r_rm - {1'b0, r_dd};
    assign div_q   = {r_q[29:0], div_ge};
    assign div_rm  = div_ge ? {div_df[32:0], 1'b0} : {r_rm[32:0], 1'b0};
    assign div_res = r_dsg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    // One digit step of the square root.
    logic [35:0] sq_in, sq_tr;
    logic        sq_ge;
    logic [32:0] sq_res;
    assign sq_in  = {r_sr[33:0], r_sx[65:64]};
    assign sq_tr  = {1'b0, r_sq, 2'b01};
    assign sq_ge  = (sq_in >= sq_tr);
    assign sq_res = {r_sq[31:0], sq_ge};

    assign fin = r_go && (r_cnt == 6'd1);

    assign o_take  = (r_state == bow_pkg::E_IDLE) && i_in_hs.valid;
    assign o_valid = (r_state == bow_pkg::E_DONE);
    assign o_ring  = r_ring;

    // Operand selection for the cross product and the offsets.
    logic signed [31:0] cr_a, cr_b, of_a;
    logic [1:0]         off_idx;
    always_comb begin
        cr_a = r_r[1];
        cr_b = r_u[2];
        case (r_k)
            3'd0: begin cr_a = r_r[1]; cr_b = r_u[2]; end
            3'd1: begin cr_a = r_r[2]; cr_b = r_u[1]; end
            3'd2: begin cr_a = r_r[2]; cr_b = r_u[0]; end
            3'd3: begin cr_a = r_r[0]; cr_b = r_u[2]; end
            3'd4: begin cr_a = r_r[0]; cr_b = r_u[1]; end
            3'd5: begin cr_a = r_r[1]; cr_b = r_u[0]; end
            default: begin cr_a = r_r[1]; cr_b = r_u[2]; end
        endcase
        off_idx = (r_k < 3'd3) ? r_k[1:0] : 2'(r_k - 3'd3);
        of_a    = (r_k < 3'd3) ? r_r[off_idx] : r_up[off_idx];
    end

    // Ring vertices from the midpoint and the axis offsets.
    logic signed [32:0] mid_s [3];
    logic signed [31:0] mid [3];
    logic [3:0][2:0][31:0] vert;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mid_s[k] = $signed({r_bone.p_start[k][31], r_bone.p_start[k]})
                     + $signed({r_bone.p_end[k][31], r_bone.p_end[k]});
            mid[k] = mid_s[k][32:1];
            vert[0][k] = sat32(36'(mid[k]) + 36'(r_ro[k]));
            vert[1][k] = sat32(36'(mid[k]) + 36'(r_uo[k]));
            vert[2][k] = sat32(36'(mid[k]) - 36'(r_ro[k]));
            vert[3][k] = sat32(36'(mid[k]) - 36'(r_uo[k]));
        end
    end

    // Next step of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bow_pkg::E_IDLE:  if (i_in_hs.valid) n_state = bow_pkg::E_SQ;
            bow_pkg::E_SQ:    if (fin && r_k == 3'd2) n_state = bow_pkg::E_LEN;
            bow_pkg::E_LEN: begin
                if (fin) begin
                    if (sq_res == 33'd0 || sq_res < 33'(bow_pkg::MIN_LEN_RAW)) begin
                        n_state = bow_pkg::E_IDLE;
                    end else begin
                        n_state = bow_pkg::E_UDIV;
                    end
                end
            end
            bow_pkg::E_UDIV:  if (fin && r_k == 3'd2) n_state = bow_pkg::E_REF;
            bow_pkg::E_REF:   n_state = bow_pkg::E_RSQ;
            bow_pkg::E_RSQ:   if (fin && r_k == 3'd2) n_state = bow_pkg::E_RSQRT;
            bow_pkg::E_RSQRT: if (fin) n_state = bow_pkg::E_RDIV;
            bow_pkg::E_RDIV:  if (fin && r_k == 3'd2) n_state = bow_pkg::E_CROSS;
            bow_pkg::E_CROSS: if (fin && r_k == 3'd5) n_state = bow_pkg::E_USQ;
            bow_pkg::E_USQ:   if (fin && r_k == 3'd2) n_state = bow_pkg::E_USQRT;
            bow_pkg::E_USQRT: if (fin) n_state = bow_pkg::E_PDIV;
            bow_pkg::E_PDIV:  if (fin && r_k == 3'd2) n_state = bow_pkg::E_RAD;
            bow_pkg::E_RAD:   if (fin) n_state = bow_pkg::E_OFF;
            bow_pkg::E_OFF:   if (fin && r_k == 3'd5) n_state = bow_pkg::E_VERT;
            bow_pkg::E_VERT:  n_state = bow_pkg::E_DONE;
            bow_pkg::E_DONE:  if (i_ready) n_state = bow_pkg::E_IDLE;
            default:          n_state = bow_pkg::E_IDLE;
        endcase
    end

    // Datapath: operand set-up, serial steps and result capture.
    always_comb begin
        n_go   = r_go;
        n_k    = r_k;
        n_cnt  = r_cnt;
        n_bone = r_bone;
        n_d    = r_d;
        n_acc  = r_acc;
        n_len  = r_len;
        n_nrm  = r_nrm;
        n_rad  = r_rad;
        n_u    = r_u;
        n_r    = r_r;
        n_up   = r_up;
        n_cx   = r_cx;
        n_ro   = r_ro;
        n_uo   = r_uo;
        n_ring = r_ring;
        n_ma   = r_ma;
        n_mp   = r_mp;
        n_msg  = r_msg;
        n_dd   = r_dd;
        n_rm   = r_rm;
        n_q    = r_q;
        n_dsg  = r_dsg;
        n_sx   = r_sx;
        n_sr   = r_sr;
        n_sq   = r_sq;

        // Serial units advance while an operation runs.
        if (r_go) begin
            n_cnt = r_cnt - 6'd1;
            n_mp  = mul_nx;
            n_rm  = div_rm;
            n_q   = div_q;
            n_sx  = r_sx << 2;
            n_sr  = sq_ge ? (sq_in - sq_tr) : sq_in;
            n_sq  = sq_res;
        end
        if (fin) begin
            n_go = 1'b0;
        end

        case (r_state)
            bow_pkg::E_IDLE: begin
                if (i_in_hs.valid) begin
                    n_bone = i_bone;
                    for (int k = 0; k < 3; k++) begin
                        n_d[k] = $signed({i_bone.p_end[k][31], i_bone.p_end[k]})
                               - $signed({i_bone.p_start[k][31], i_bone.p_start[k]});
                    end
                    n_acc = 66'd0;
                    n_k   = 3'd0;
                    n_go  = 1'b0;
                end
            end
            bow_pkg::E_SQ, bow_pkg::E_RSQ, bow_pkg::E_USQ: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::MUL_STEPS;
                    n_msg = 1'b0;
                    if (r_state == bow_pkg::E_SQ) begin
                        n_ma = {1'b0, mag33(r_d[r_k[1:0]])};
                    end else if (r_state == bow_pkg::E_RSQ) begin
                        n_ma = {1'b0, mag33(33'(r_r[r_k[1:0]]))};
                    end else begin
                        n_ma = {1'b0, mag33(33'(r_up[r_k[1:0]]))};
                    end
                    n_mp = {34'd0, n_ma};
                end else if (fin) begin
                    n_acc = r_acc + mul_nx[65:0];
                    n_k   = (r_k == 3'd2) ? 3'd0 : r_k + 3'd1;
                end
            end
            bow_pkg::E_LEN, bow_pkg::E_RSQRT, bow_pkg::E_USQRT: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::SQRT_STEPS;
                    n_sx  = r_acc;
                    n_sr  = 36'd0;
                    n_sq  = 33'd0;
                end else if (fin) begin
                    if (r_state == bow_pkg::E_LEN) begin
                        n_len = sq_res;
                    end else begin
                        n_nrm = sq_res;
                    end
                    n_k = 3'd0;
                end
            end
            bow_pkg::E_UDIV, bow_pkg::E_RDIV, bow_pkg::E_PDIV: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::DIV_STEPS;
                    n_q   = 31'd0;
                    if (r_state == bow_pkg::E_UDIV) begin
                        n_dd  = r_len;
                        n_rm  = {1'b0, mag33(r_d[r_k[1:0]])};
                        n_dsg = r_d[r_k[1:0]][32];
                    end else if (r_state == bow_pkg::E_RDIV) begin
                        n_dd  = r_nrm;
                        n_rm  = {1'b0, mag33(33'(r_r[r_k[1:0]]))};
                        n_dsg = r_r[r_k[1:0]][31];
                    end else begin
                        n_dd  = r_nrm;
                        n_rm  = {1'b0, mag33(33'(r_up[r_k[1:0]]))};
                        n_dsg = r_up[r_k[1:0]][31];
                    end
                end else if (fin) begin
                    if (r_state == bow_pkg::E_UDIV) begin
                        n_u[r_k[1:0]] = div_res;
                    end else if (r_state == bow_pkg::E_RDIV) begin
                        n_r[r_k[1:0]] = (r_dd == 33'd0) ? 32'sd0 : div_res;
                    end else begin
                        n_up[r_k[1:0]] = (r_dd == 33'd0) ? 32'sd0 : div_res;
                    end
                    n_k = (r_k == 3'd2) ? 3'd0 : r_k + 3'd1;
                    if (r_k == 3'd2) begin
                        n_acc = 66'd0;
                    end
                end
            end
            bow_pkg::E_REF: begin
                // Reference axis Z, or X when the bone is nearly vertical.
                if (mag33(33'(r_u[2])) < 33'(bow_pkg::UPSWITCH_Q30)) begin
                    n_r[0] = r_u[1];
                    n_r[1] = -r_u[0];
                    n_r[2] = 32'sd0;
                end else begin
                    n_r[0] = 32'sd0;
                    n_r[1] = r_u[2];
                    n_r[2] = -r_u[1];
                end
                n_acc = 66'd0;
                n_k   = 3'd0;
            end
            bow_pkg::E_CROSS: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::MUL_STEPS;
                    n_ma  = {1'b0, mag33(33'(cr_a))};
                    n_mp  = {34'd0, 1'b0, mag33(33'(cr_b))};
                    n_msg = cr_a[31] ^ cr_b[31];
                end else if (fin) begin
                    if (!r_k[0]) begin
                        n_cx = mul_sp;
                    end else begin
                        n_cx = r_cx - mul_sp;
                        n_up[2'(r_k >> 1)] = 32'(n_cx >>> bow_pkg::UNIT_BITS);
                    end
                    n_k = (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        n_acc = 66'd0;
                    end
                end
            end
            bow_pkg::E_RAD: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::MUL_STEPS;
                    n_ma  = {1'b0, r_len};
                    n_mp  = {34'd0, 18'd0, i_scale};
                    n_msg = 1'b0;
                end else if (fin) begin
                    n_rad = mul_nx[48:16];
                    n_k   = 3'd0;
                end
            end
            bow_pkg::E_OFF: begin
                if (!r_go) begin
                    n_go  = 1'b1;
                    n_cnt = bow_pkg::MUL_STEPS;
                    n_ma  = {1'b0, mag33(33'(of_a))};
                    n_mp  = {34'd0, 1'b0, r_rad};
                    n_msg = of_a[31];
                end else if (fin) begin
                    if (r_k < 3'd3) begin
                        n_ro[off_idx] = 35'(mul_sp >>> bow_pkg::UNIT_BITS);
                    end else begin
                        n_uo[off_idx] = 35'(mul_sp >>> bow_pkg::UNIT_BITS);
                    end
                    n_k = (r_k == 3'd5) ? 3'd0 : r_k + 3'd1;
                end
            end
            bow_pkg::E_VERT: begin
                n_ring.p_start = r_bone.p_start;
                n_ring.p_end   = r_bone.p_end;
                n_ring.color   = r_bone.color;
                n_ring.vert    = vert;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bow_pkg::E_IDLE;
            r_go    <= 1'b0;
            r_k     <= 3'd0;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    // Working values.
    always_ff @(posedge i_clk) begin
        r_bone <= n_bone;
        r_d    <= n_d;
        r_acc  <= n_acc;
        r_len  <= n_len;
        r_nrm  <= n_nrm;
        r_rad  <= n_rad;
        r_u    <= n_u;
        r_r    <= n_r;
        r_up   <= n_up;
        r_cx   <= n_cx;
        r_ro   <= n_ro;
        r_uo   <= n_uo;
        r_ring <= n_ring;
        r_ma   <= n_ma;
        r_mp   <= n_mp;
        r_msg  <= n_msg;
        r_dd   <= n_dd;
        r_rm   <= n_rm;
        r_q    <= n_q;
        r_dsg  <= n_dsg;
        r_sx   <= n_sx;
        r_sr   <= n_sr;
        r_sq   <= n_sq;
    end

endmodule

/* rtl/core/bow_emit.sv */
// Segment emitter: walks every edge of one finished bone into an output register.
// Depends on bow_pkg for the ring and segment types.
module bow_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bow_pkg::t_ring i_ring,
    output logic           o_empty,
    input  logic           i_pop,
    output bow_pkg::t_seg  o_seg
);

    bow_pkg::t_ring r_hold;
    logic           r_busy, n_busy;
    logic [3:0]     r_seg, n_seg;
    logic           r_ov, n_ov;
    bow_pkg::t_seg  r_out, seg;
    logic           ld_out, ld_ring;
    logic [1:0]     vi;

    assign o_ready = !r_busy;
    assign o_empty = !r_ov;
    assign o_seg   = r_out;
    assign ld_ring = i_valid && !r_busy;
    assign ld_out  = r_busy && (!r_ov || i_pop);

    // Edge selection: ring, then start pyramid, then end pyramid.
    always_comb begin
        vi        = r_seg[1:0];
        seg.color = r_hold.color;
        seg.last  = (r_seg == 4'(bow_pkg::NUM_SEG - 1));
        seg.pb    = r_hold.vert[vi];
        if (r_seg < 4'd4) begin
            seg.pa = r_hold.vert[vi];
            seg.pb = r_hold.vert[2'(vi + 2'd1)];
        end else if (r_seg < 4'd8) begin
            seg.pa = r_hold.p_start;
        end else begin
            seg.pa = r_hold.p_end;
        end
    end

    // Walk and output register control.
    always_comb begin
        n_busy = r_busy;
        n_seg  = r_seg;
        n_ov   = r_ov;
        if (i_pop && r_ov) begin
            n_ov = 1'b0;
        end
        if (ld_out) begin
            n_ov  = 1'b1;
            n_seg = r_seg + 4'd1;
            if (seg.last) begin
                n_busy = 1'b0;
                n_seg  = 4'd0;
            end
        end
        if (ld_ring) begin
            n_busy = 1'b1;
            n_seg  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_seg  <= n_seg;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_ring) begin
            r_hold <= i_ring;
        end
        if (ld_out) begin
            r_out <= seg;
        end
    end

endmodule

/* rtl/core/bone_octahedron_wireframe_top.sv */
// Top level of the bone octahedron wireframe generator: scale register and the
// front queue, arithmetic engine and segment emitter. Depends on bow_pkg and the bow_* modules.
//
//  Channel    Handshake               Transaction
//  --------   ---------------------   ---------------------------------------
//  bone in    push / full             start and end point, colour tag
//  segment    empty / pop             one line segment, last flag on the 12th
//  config     i_cfg_valid/o_cfg_ready bone_scale, unsigned Q0.16
//
// In the engine, every multiply, divide and square root of a bone goes through
// its own serial unit, a bit or a digit per cycle.
// The twelve segments of a bone leave while the engine works on the next bone.
// Reset is synchronous and active low; it empties the queues and sets the scale to 3277.
// A full result side stalls the emitter, then the engine, then the input queue.
module bone_octahedron_wireframe_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_start_x,
    input  logic [31:0] i_start_y,
    input  logic [31:0] i_start_z,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    input  logic [31:0] i_line_color,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_seg_start_x,
    output logic [31:0] o_seg_start_y,
    output logic [31:0] o_seg_start_z,
    output logic [31:0] o_seg_end_x,
    output logic [31:0] o_seg_end_y,
    output logic [31:0] o_seg_end_z,
    output logic [31:0] o_seg_color,
    output logic        o_seg_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [bow_pkg::SCALE_W-1:0] r_scale;
    bow_pkg::t_bone in_bone, q_bone;
    bow_pkg::t_hs   q_hs;
    bow_pkg::t_ring ring;
    logic           q_take, ring_valid, ring_ready;
    bow_pkg::t_seg  seg;

    assign o_cfg_ready = 1'b1;

    // Scale register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= bow_pkg::SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    // Pack the input fields.
    always_comb begin
        in_bone.p_start[0] = i_start_x;
        in_bone.p_start[1] = i_start_y;
        in_bone.p_start[2] = i_start_z;
        in_bone.p_end[0]   = i_end_x;
        in_bone.p_end[1]   = i_end_y;
        in_bone.p_end[2]   = i_end_z;
        in_bone.color      = i_line_color;
    end

    bow_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_bone  (in_bone),
        .o_full  (full),
        .o_valid (q_hs.valid),
        .i_take  (q_take),
        .o_bone  (q_bone)
    );

    assign q_hs.ready = q_take;

    bow_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_scale),
        .i_in_hs (q_hs),
        .o_take  (q_take),
        .i_bone  (q_bone),
        .o_valid (ring_valid),
        .i_ready (ring_ready),
        .o_ring  (ring)
    );

    bow_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ring_valid),
        .o_ready (ring_ready),
        .i_ring  (ring),
        .o_empty (empty),
        .i_pop   (pop),
        .o_seg   (seg)
    );

    // Unpack the result fields.
    assign o_seg_start_x = seg.pa[0];
    assign o_seg_start_y = seg.pa[1];
    assign o_seg_start_z = seg.pa[2];
    assign o_seg_end_x   = seg.pb[0];
    assign o_seg_end_y   = seg.pb[1];
    assign o_seg_end_z   = seg.pb[2];
    assign o_seg_color   = seg.color;
    assign o_seg_last    = seg.last;

endmodule
